// ----- hw/rtl/nfps_pkg.sv -----
// Shared types, constants, saturation helpers and the microcode table of the shade unit.
`default_nettype none

package nfps_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FRAC_W = 20;
    localparam int unsigned PC_W   = 7;
    localparam int unsigned RA_W   = 5;
    localparam int unsigned SHADE_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLIDER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_BIAS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_MIX      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 2'd3;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_MULW,
        S_LEN2,
        S_SQRT,
        S_SQW,
        S_DIV,
        S_DIVW,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LDI,
        OP_LDS,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_LEN,
        OP_SHADE,
        OP_LOOP,
        OP_JMP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [RA_W-1:0]  dst;
        logic [RA_W-1:0]  a;
        logic [RA_W-1:0]  b;
        logic [DATA_W-1:0] imm;
    } t_uop;

    // sources for OP_LDS
    localparam logic [2:0] SRC_CX   = 3'd0;
    localparam logic [2:0] SRC_CY   = 3'd1;
    localparam logic [2:0] SRC_TM   = 3'd2;
    localparam logic [2:0] SRC_BIAS = 3'd3;
    localparam logic [2:0] SRC_RMIX = 3'd4;

    // register file map
    localparam logic [RA_W-1:0] R_ZERO  = 5'd0;
    localparam logic [RA_W-1:0] R_ONE   = 5'd1;
    localparam logic [RA_W-1:0] R_TWO   = 5'd2;
    localparam logic [RA_W-1:0] R_THREE = 5'd3;
    localparam logic [RA_W-1:0] R_FOUR  = 5'd4;
    localparam logic [RA_W-1:0] R_HALF  = 5'd5;
    localparam logic [RA_W-1:0] R_THIRD = 5'd6;
    localparam logic [RA_W-1:0] R_SCALE = 5'd7;
    localparam logic [RA_W-1:0] R_TM    = 5'd8;
    localparam logic [RA_W-1:0] R_BIAS  = 5'd9;
    localparam logic [RA_W-1:0] R_RMIX  = 5'd10;
    localparam logic [RA_W-1:0] R_UX    = 5'd11;
    localparam logic [RA_W-1:0] R_UY    = 5'd12;
    localparam logic [RA_W-1:0] R_PX    = 5'd13;
    localparam logic [RA_W-1:0] R_PY    = 5'd14;
    localparam logic [RA_W-1:0] R_KX    = 5'd15;
    localparam logic [RA_W-1:0] R_KY    = 5'd16;
    localparam logic [RA_W-1:0] R_DIST  = 5'd17;
    localparam logic [RA_W-1:0] T0  = 5'd18;
    localparam logic [RA_W-1:0] T1  = 5'd19;
    localparam logic [RA_W-1:0] T2  = 5'd20;
    localparam logic [RA_W-1:0] T3  = 5'd21;
    localparam logic [RA_W-1:0] T4  = 5'd22;
    localparam logic [RA_W-1:0] T5  = 5'd23;
    localparam logic [RA_W-1:0] T6  = 5'd24;
    localparam logic [RA_W-1:0] T7  = 5'd25;
    localparam logic [RA_W-1:0] T8  = 5'd26;
    localparam logic [RA_W-1:0] T9  = 5'd27;
    localparam logic [RA_W-1:0] T10 = 5'd28;
    localparam logic [RA_W-1:0] T11 = 5'd29;
    localparam logic [RA_W-1:0] T12 = 5'd30;
    localparam logic [RA_W-1:0] T13 = 5'd31;

    localparam logic [PC_W-1:0] UC_HEAD = 7'd19;
    localparam logic [PC_W-1:0] UC_TAIL = 7'd112;

    function automatic logic signed [63:0] sx64(input logic signed [DATA_W-1:0] v);
        return $signed({{(64-DATA_W){v[DATA_W-1]}}, v});
    endfunction

    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > sx64(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < sx64(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic t_uop uo(input t_op op, input logic [RA_W-1:0] d,
                                input logic [RA_W-1:0] a, input logic [RA_W-1:0] b);
        t_uop u;
        u.op  = op;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        u.imm = '0;
        return u;
    endfunction

    function automatic t_uop ui(input t_op op, input logic [RA_W-1:0] d,
                                input logic [DATA_W-1:0] imm);
        t_uop u;
        u.op  = op;
        u.dst = d;
        u.a   = R_ZERO;
        u.b   = R_ZERO;
        u.imm = imm;
        return u;
    endfunction

    // Microprogram: constants and seed, then one Newton step per pass of the loop,
    // then the shade tail.
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            0:   u = ui(OP_LDI, R_ZERO,  32'd0);
            1:   u = ui(OP_LDI, R_ONE,   32'd1048576);
            2:   u = ui(OP_LDI, R_TWO,   32'd2097152);
            3:   u = ui(OP_LDI, R_THREE, 32'd3145728);
            4:   u = ui(OP_LDI, R_FOUR,  32'd4194304);
            5:   u = ui(OP_LDI, R_HALF,  32'd524288);
            6:   u = ui(OP_LDI, R_THIRD, 32'd349525);
            7:   u = ui(OP_LDI, R_SCALE, 32'd4194);
            8:   u = ui(OP_LDS, R_TM,   32'(SRC_TM));
            9:   u = ui(OP_LDS, R_BIAS, 32'(SRC_BIAS));
            10:  u = ui(OP_LDS, R_RMIX, 32'(SRC_RMIX));
            11:  u = ui(OP_LDS, R_UX,   32'(SRC_CX));
            12:  u = ui(OP_LDS, R_UY,   32'(SRC_CY));
            13:  u = ui(OP_LDS, R_PX,   32'(SRC_CX));
            14:  u = ui(OP_LDS, R_PY,   32'(SRC_CY));
            15:  u = uo(OP_MUL, T0, R_TM, R_HALF);
            16:  u = uo(OP_ADD, R_KX, R_THIRD, T0);
            17:  u = uo(OP_ADD, R_KY, R_TM, R_ZERO);
            18:  u = uo(OP_ADD, R_DIST, R_ZERO, R_ZERO);
            19:  u = ui(OP_LOOP, R_ZERO, 32'(UC_TAIL));
            // z = u * k
            20:  u = uo(OP_MUL, T2, R_UX, R_KX);
            21:  u = uo(OP_MUL, T3, R_UY, R_KY);
            22:  u = uo(OP_SUB, T0, T2, T3);
            23:  u = uo(OP_MUL, T2, R_UX, R_KY);
            24:  u = uo(OP_MUL, T3, R_KX, R_UY);
            25:  u = uo(OP_ADD, T1, T2, T3);
            // (z-1)(z+1)
            26:  u = uo(OP_SUB, T4, T0, R_ONE);
            27:  u = uo(OP_ADD, T5, T0, R_ONE);
            28:  u = uo(OP_MUL, T2, T4, T5);
            29:  u = uo(OP_MUL, T3, T1, T1);
            30:  u = uo(OP_SUB, T6, T2, T3);
            31:  u = uo(OP_MUL, T2, T4, T1);
            32:  u = uo(OP_MUL, T3, T5, T1);
            33:  u = uo(OP_ADD, T7, T2, T3);
            // f = ab * (z-p)
            34:  u = uo(OP_SUB, T4, T0, R_PX);
            35:  u = uo(OP_SUB, T5, T1, R_PY);
            36:  u = uo(OP_MUL, T2, T6, T4);
            37:  u = uo(OP_MUL, T3, T7, T5);
            38:  u = uo(OP_SUB, T8, T2, T3);
            39:  u = uo(OP_MUL, T2, T6, T5);
            40:  u = uo(OP_MUL, T3, T4, T7);
            41:  u = uo(OP_ADD, T9, T2, T3);
            // Jacobian terms
            42:  u = uo(OP_SUB, T4, R_PX, T0);
            43:  u = uo(OP_SUB, T5, R_PY, T1);
            44:  u = uo(OP_SUB, T6, T5, T1);
            45:  u = uo(OP_MUL, T2, T4, T0);
            46:  u = uo(OP_MUL, T3, T5, T1);
            47:  u = uo(OP_SUB, T7, T2, T3);
            48:  u = uo(OP_MUL, T2, T7, R_TWO);
            49:  u = uo(OP_MUL, T3, T1, T1);
            50:  u = uo(OP_ADD, T2, T2, T3);
            51:  u = uo(OP_ADD, T2, T2, R_ONE);
            52:  u = uo(OP_MUL, T3, T0, T0);
            53:  u = uo(OP_SUB, T2, T2, T3);
            54:  u = uo(OP_SUB, T10, R_ZERO, T2);
            55:  u = uo(OP_MUL, T2, T6, T0);
            56:  u = uo(OP_MUL, T3, T4, T1);
            57:  u = uo(OP_ADD, T7, T2, T3);
            58:  u = uo(OP_MUL, T11, T7, R_TWO);
            59:  u = uo(OP_SUB, T12, R_ZERO, T11);
            // determinant and inverse
            60:  u = uo(OP_MUL, T2, T10, T10);
            61:  u = uo(OP_MUL, T3, T11, T12);
            62:  u = uo(OP_SUB, T13, T2, T3);
            63:  u = uo(OP_DIV, T2, T10, T13);
            64:  u = uo(OP_DIV, T3, T12, T13);
            65:  u = uo(OP_SUB, T4, R_ZERO, T12);
            66:  u = uo(OP_DIV, T4, T4, T13);
            // offset
            67:  u = uo(OP_MUL, T5, T2, T8);
            68:  u = uo(OP_MUL, T6, T3, T9);
            69:  u = uo(OP_ADD, T5, T5, T6);
            70:  u = uo(OP_SUB, T5, R_ZERO, T5);
            71:  u = uo(OP_MUL, T6, T4, T8);
            72:  u = uo(OP_MUL, T7, T2, T9);
            73:  u = uo(OP_ADD, T6, T6, T7);
            74:  u = uo(OP_SUB, T6, R_ZERO, T6);
            75:  u = uo(OP_SUB, T7, R_ZERO, T6);
            76:  u = uo(OP_MUL, T7, T7, R_RMIX);
            77:  u = uo(OP_ADD, T2, T5, T7);
            78:  u = uo(OP_MUL, T7, T5, R_RMIX);
            79:  u = uo(OP_ADD, T3, T6, T7);
            // R matrix
            80:  u = uo(OP_MUL, T4, T0, R_THREE);
            81:  u = uo(OP_SUB, T4, R_PX, T4);
            82:  u = uo(OP_MUL, T5, T1, R_THREE);
            83:  u = uo(OP_SUB, T5, R_PY, T5);
            84:  u = uo(OP_MUL, T6, T4, T4);
            85:  u = uo(OP_MUL, T6, T6, R_FOUR);
            86:  u = uo(OP_MUL, T7, T4, T5);
            87:  u = uo(OP_MUL, T7, T7, R_FOUR);
            88:  u = uo(OP_SUB, T7, R_ZERO, T7);
            89:  u = uo(OP_MUL, T8, T5, T5);
            90:  u = uo(OP_MUL, T8, T8, R_FOUR);
            91:  u = uo(OP_MUL, T9, T6, T2);
            92:  u = uo(OP_MUL, T10, T7, T3);
            93:  u = uo(OP_ADD, T9, T9, T10);
            94:  u = uo(OP_MUL, T10, T7, T2);
            95:  u = uo(OP_MUL, T11, T8, T3);
            96:  u = uo(OP_ADD, T10, T10, T11);
            97:  u = uo(OP_MUL, T11, T6, T9);
            98:  u = uo(OP_MUL, T12, T7, T10);
            99:  u = uo(OP_ADD, T11, T11, T12);
            100: u = uo(OP_MUL, T12, T7, T9);
            101: u = uo(OP_MUL, T13, T8, T10);
            102: u = uo(OP_ADD, T12, T12, T13);
            // distance term and position update
            103: u = uo(OP_LEN, T4, T2, T3);
            104: u = uo(OP_MUL, T4, T4, R_FOUR);
            105: u = uo(OP_LEN, T5, T11, T12);
            106: u = uo(OP_ADD, T5, R_BIAS, T5);
            107: u = uo(OP_DIV, T5, T4, T5);
            108: u = uo(OP_ADD, R_DIST, R_DIST, T5);
            109: u = uo(OP_ADD, R_UX, R_UX, T2);
            110: u = uo(OP_ADD, R_UY, R_UY, T3);
            111: u = ui(OP_JMP, R_ZERO, 32'(UC_HEAD));
            112: u = uo(OP_MUL, T0, R_DIST, R_SCALE);
            113: u = uo(OP_SHADE, R_ZERO, T0, R_ZERO);
            default: u = uo(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/newton_fractal_pixel_shade_unit.sv -----
// Newton fractal pixel shade unit: microcoded sequencer around one shared datapath.
`default_nettype none

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------
// input     | in        | i_in_valid / o_in_stall   | i_coord_x, i_coord_y (Q12.20)
// result    | out       | o_out_valid / i_out_stall | o_shade (Q1.15)
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel runs the constant and seed micro-ops, then steps = min(iteration_count, MAX_STEPS)
// passes of the Newton loop, then the shade tail; a zero divisor skips the divider.
// Each micro-op goes through operand fetch, then execute; a multiply adds a write-back state,
// a divide runs the bit-serial divider and a length a square root; the four divides dominate.
// Reset (synchronous, active low) returns the sequencer to idle and the configuration to defaults.
// The input is stalled until the result transfer completes; a stalled result holds.

module newton_fractal_pixel_shade_unit #(
    parameter int unsigned MAX_STEPS = 255
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [nfps_pkg::DATA_W-1:0]     i_coord_x,
    input  wire logic signed [nfps_pkg::DATA_W-1:0]     i_coord_y,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [nfps_pkg::SHADE_W-1:0]                o_shade,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [nfps_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [nfps_pkg::DATA_W-1:0]            i_cfg_data
);
    import nfps_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);
    localparam int unsigned DVD_W = DATA_W + FRAC_W;

    // configuration
    logic signed [DATA_W-1:0] r_time_slider;
    logic signed [DATA_W-1:0] r_distance_bias;
    logic signed [DATA_W-1:0] r_rotate_mix;
    logic [7:0]               r_iteration_count;

    // sequencer
    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] steps_cap;

    // register file
    logic signed [DATA_W-1:0] r_rf [2**RA_W];
    logic                     rf_we;
    logic [RA_W-1:0]          rf_waddr;
    logic signed [DATA_W-1:0] rf_wdata;

    // datapath
    t_uop                     uc_cur;
    t_uop                     r_uop;
    logic signed [DATA_W-1:0] r_opa, r_opb;
    logic signed [DATA_W-1:0] r_cx, r_cy;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [63:0]       mul_p;
    logic signed [63:0]       r_prod;
    logic [63:0]              r_rad;
    logic [DATA_W-1:0]        r_root;
    logic [DATA_W+1:0]        r_srem;
    logic [DVD_W-1:0]         r_dvd;
    logic [DATA_W-1:0]        r_dvs;
    logic [DATA_W-1:0]        r_rem;
    logic                     r_neg;
    logic [5:0]               r_it;
    logic [SHADE_W-1:0]       r_shade;

    logic [DATA_W-1:0]        abs_a, abs_b;
    logic signed [DATA_W-1:0] lds_val;
    logic signed [63:0]       quot_s;
    logic signed [20:0]       dev_s;
    logic [20:0]              dev_abs;
    logic [20:0]              tent;
    logic [DATA_W+1:0]        srem_sh_lo;
    logic [DATA_W+3:0]        srem_sh, sq_trial, sq_diff;
    logic                     sq_ge;
    logic [DATA_W:0]          dv_sh, dv_diff;
    logic                     dv_ge;

    assign steps_cap = ({24'd0, r_iteration_count} > 32'(MAX_STEPS)) ?
                       CNT_W'(MAX_STEPS) : CNT_W'(r_iteration_count);

    assign uc_cur = ucode(r_pc);

    // configuration writes land at any time; the user must issue them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_slider     <= '0;
            r_distance_bias   <= 32'sd1048576;
            r_rotate_mix      <= '0;
            r_iteration_count <= 8'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIME_SLIDER:     r_time_slider     <= i_cfg_data;
                CFG_DISTANCE_BIAS:   r_distance_bias   <= i_cfg_data;
                CFG_ROTATE_MIX:      r_rotate_mix      <= i_cfg_data;
                CFG_ITERATION_COUNT: r_iteration_count <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // shared multiplier: squares of a for the first half of a length, b for the second
    always_comb begin
        mul_a = r_opa;
        mul_b = r_opb;
        if (r_state == S_LEN2) begin
            mul_a = r_opb;
        end else if (r_uop.op == OP_LEN) begin
            mul_b = r_opa;
        end
    end
    assign mul_p = mul_a * mul_b;

    assign abs_a = r_opa[DATA_W-1] ? DATA_W'(-r_opa) : DATA_W'(r_opa);
    assign abs_b = r_opb[DATA_W-1] ? DATA_W'(-r_opb) : DATA_W'(r_opb);

    always_comb begin
        case (r_uop.imm[2:0])
            SRC_CX:   lds_val = r_cx;
            SRC_CY:   lds_val = r_cy;
            SRC_TM:   lds_val = r_time_slider;
            SRC_BIAS: lds_val = r_distance_bias;
            SRC_RMIX: lds_val = r_rotate_mix;
            default:  lds_val = '0;
        endcase
    end

    // tent over the fractional part of the scaled distance
    assign dev_s   = $signed({1'b0, r_opa[FRAC_W-1:0]}) - 21'sd524288;
    assign dev_abs = dev_s[20] ? 21'(-dev_s) : 21'(dev_s);
    assign tent    = 21'd1048576 - {dev_abs[19:0], 1'b0};

    // one root digit per cycle
    assign srem_sh_lo = r_srem;
    assign srem_sh    = {srem_sh_lo, r_rad[63:62]};
    assign sq_trial   = {2'b00, r_root, 2'b01};
    assign sq_ge      = srem_sh >= sq_trial;
    assign sq_diff    = srem_sh - sq_trial;

    // one quotient bit per cycle
    assign dv_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign dv_ge   = dv_sh >= {1'b0, r_dvs};
    assign dv_diff = dv_sh - {1'b0, r_dvs};

    assign quot_s = r_neg ? -$signed({{(64-DVD_W){1'b0}}, r_dvd})
                          :  $signed({{(64-DVD_W){1'b0}}, r_dvd});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
        end
    end

    // next state, micro-op sequencing and register file write-back
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        rf_we    = 1'b0;
        rf_waddr = r_uop.dst;
        rf_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FETCH;
                    n_pc    = '0;
                    n_cnt   = steps_cap;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FETCH;
                n_pc    = r_pc + 1'b1;
                case (r_uop.op)
                    OP_LDI: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_uop.imm;
                    end
                    OP_LDS: begin
                        rf_we    = 1'b1;
                        rf_wdata = lds_val;
                    end
                    OP_ADD: begin
                        rf_we    = 1'b1;
                        rf_wdata = sat64(sx64(r_opa) + sx64(r_opb));
                    end
                    OP_SUB: begin
                        rf_we    = 1'b1;
                        rf_wdata = sat64(sx64(r_opa) - sx64(r_opb));
                    end
                    OP_MUL: begin
                        n_state = S_MULW;
                        n_pc    = r_pc;
                    end
                    OP_DIV: begin
                        if (r_opb == '0) begin
                            rf_we = 1'b1;
                            if (r_opa > 0) begin
                                rf_wdata = Q_MAX;
                            end else if (r_opa < 0) begin
                                rf_wdata = Q_MIN;
                            end else begin
                                rf_wdata = '0;
                            end
                        end else begin
                            n_state = S_DIV;
                            n_pc    = r_pc;
                        end
                    end
                    OP_LEN: begin
                        n_state = S_LEN2;
                        n_pc    = r_pc;
                    end
                    OP_SHADE: begin
                        n_state = S_SQRT;
                        n_pc    = r_pc;
                    end
                    OP_LOOP: begin
                        if (r_cnt == '0) begin
                            n_pc = r_uop.imm[PC_W-1:0];
                        end else begin
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    OP_JMP: begin
                        n_pc = r_uop.imm[PC_W-1:0];
                    end
                    default: ;
                endcase
            end
            S_MULW: begin
                rf_we    = 1'b1;
                rf_wdata = sat64(r_prod >>> FRAC_W);
                n_pc     = r_pc + 1'b1;
                n_state  = S_FETCH;
            end
            S_LEN2: begin
                n_state = S_SQRT;
            end
            S_DIV: begin
                if (r_it == '0) begin
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                rf_we    = 1'b1;
                rf_wdata = sat64(quot_s);
                n_pc     = r_pc + 1'b1;
                n_state  = S_FETCH;
            end
            S_SQRT: begin
                if (r_it == '0) begin
                    n_state = S_SQW;
                end
            end
            S_SQW: begin
                if (r_uop.op == OP_LEN) begin
                    rf_we    = 1'b1;
                    rf_wdata = r_root[DATA_W-1] ? Q_MAX : $signed(r_root);
                    n_pc     = r_pc + 1'b1;
                    n_state  = S_FETCH;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cx <= i_coord_x;
                r_cy <= i_coord_y;
            end
            S_FETCH: begin
                r_uop <= uc_cur;
                r_opa <= r_rf[uc_cur.a];
                r_opb <= r_rf[uc_cur.b];
            end
            S_EXEC: begin
                r_prod <= mul_p;
                r_dvd  <= {abs_a, {FRAC_W{1'b0}}};
                r_dvs  <= abs_b;
                r_rem  <= '0;
                r_neg  <= r_opa[DATA_W-1] ^ r_opb[DATA_W-1];
                r_it   <= 6'(DVD_W - 1);
                if (r_uop.op == OP_SHADE) begin
                    r_rad  <= {23'd0, tent, {FRAC_W{1'b0}}};
                    r_root <= '0;
                    r_srem <= '0;
                    r_it   <= 6'(DATA_W - 1);
                end
            end
            S_LEN2: begin
                r_rad  <= r_prod + mul_p;
                r_root <= '0;
                r_srem <= '0;
                r_it   <= 6'(DATA_W - 1);
            end
            S_DIV: begin
                r_rem <= dv_ge ? dv_diff[DATA_W-1:0] : dv_sh[DATA_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], dv_ge};
                r_it  <= r_it - 1'b1;
            end
            S_SQRT: begin
                r_srem <= sq_ge ? sq_diff[DATA_W+1:0] : srem_sh[DATA_W+1:0];
                r_root <= {r_root[DATA_W-2:0], sq_ge};
                r_rad  <= {r_rad[61:0], 2'b00};
                r_it   <= r_it - 1'b1;
            end
            S_SQW: begin
                r_shade <= r_root[20:5];
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_shade     = r_shade;

    // the sequencer starts at the first micro-op after each accepted pixel
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_FETCH && r_pc == '0))
        else $error("pixel accepted without restarting the microprogram");

    // a pending result keeps the input closed
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result waits");

    // shade never exceeds one (Q1.15)
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_shade <= 16'd32768))
        else $error("shade out of range");

    // the divider never iterates on a zero divisor
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider running with zero divisor");

endmodule

`default_nettype wire
